### hdl/esc_pkg.sv
`default_nettype none

package esc_pkg;

    // Field widths of the transfer payloads.
    localparam int EPOCH_W  = 32;
    localparam int SEC_W    = 6;
    localparam int MIN_W    = 6;
    localparam int HOUR_W   = 5;
    localparam int DAY_W    = 5;
    localparam int MONTH_W  = 4;
    localparam int YEAR_W   = 12;

    // Internal widths: second of the day, second of the hour, the whole-day count and the year length.
    localparam int REM_W    = 17;
    localparam int HREM_W   = 12;
    localparam int DAYS_W   = 16;
    localparam int YDAYS_W  = 9;

    // Calendar and clock constants.
    localparam logic [REM_W-1:0]   SECS_PER_DAY  = 17'd86400;
    localparam logic [HREM_W-1:0]  SECS_PER_HOUR = 12'd3600;
    localparam logic [SEC_W-1:0]   SECS_PER_MIN  = 6'd60;
    localparam logic [YEAR_W-1:0]  FIRST_YEAR   = 12'd2000;
    localparam logic [YDAYS_W-1:0] DAYS_LEAP    = 9'd366;
    localparam logic [YDAYS_W-1:0] DAYS_COMMON  = 9'd365;
    localparam logic [MONTH_W-1:0] LAST_MONTH   = 4'd11;
    localparam logic [6:0]         LAST_YEAR_OF_CENTURY = 7'd99;

    // Division by reciprocal multiplication. Each divisor is split into a power of
    // two, taken off by a shift, and an odd part: 86400 = 128 * 675,
    // 3600 = 16 * 225 and 60 = 4 * 15. The reciprocal of the odd part is rounded
    // up, and the rounding error times the largest shifted value stays below the
    // scale, so the quotient is exact over the whole input range.
    localparam int DAY_PRE     = 7;
    localparam int HOUR_PRE    = 4;
    localparam int MIN_PRE     = 2;
    localparam int DAY_RCP_W   = 26;
    localparam int HOUR_RCP_W  = 14;
    localparam int MIN_RCP_W   = 11;
    localparam int DAY_SH      = 35;
    localparam int HOUR_SH     = 21;
    localparam int MIN_SH      = 14;
    localparam int DAY_PROD_W  = EPOCH_W - DAY_PRE + DAY_RCP_W;
    localparam int HOUR_PROD_W = REM_W - HOUR_PRE + HOUR_RCP_W;
    localparam int MIN_PROD_W  = HREM_W - MIN_PRE + MIN_RCP_W;
    localparam logic [DAY_RCP_W-1:0]  DAY_RCP  = 26'd50903317;   // 2^35 / 675, rounded up
    localparam logic [HOUR_RCP_W-1:0] HOUR_RCP = 14'd9321;       // 2^21 / 225, rounded up
    localparam logic [MIN_RCP_W-1:0]  MIN_RCP  = 11'd1093;       // 2^14 / 15, rounded up

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic start;       // load the seconds count and clear the calendar
        logic day_quo;     // whole days of the seconds count
        logic day_rem;     // second of the day
        logic hour_quo;    // hour of the day
        logic hour_rem;    // second of the hour
        logic min_quo;     // minute of the hour
        logic min_rem;     // second of the minute
        logic year_step;   // take one whole year off the day count
        logic month_step;  // take one whole month off the day count
        logic out_load;    // copy the result into the output register
    } esc_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic year_more;   // days left cover the current year
        logic month_more;  // days left cover the current month, before the last month
    } esc_status_t;

    // Length of a month counted from zero, February depending on the leap flag.
    function automatic logic [DAY_W:0] month_len(input logic leap,
                                                 input logic [MONTH_W-1:0] m);
        logic [DAY_W:0] len;
        begin
            case (m)
                4'd1:                       len = leap ? 6'd29 : 6'd28;
                4'd3, 4'd5, 4'd8, 4'd10:    len = 6'd30;
                default:                    len = 6'd31;
            endcase
            return len;
        end
    endfunction

endpackage

`default_nettype wire

### hdl/epoch_seconds_to_calendar_top.sv
`default_nettype none

// Channel   Handshake               Payload
// input     in_valid / in_ready     epoch_seconds
// output    out_valid / out_ready   second_of_minute, minute_of_hour, hour_of_day,
//                                   day_of_month, month_of_year, calendar_year
//
// An item runs from its transfer to out_valid through six reciprocal-multiply and subtract
// steps, a walk over the whole years (0 to 136) and then the whole months (0 to 11), one year
// or month per cycle, and then the load of the output register once that register is free;
// in_ready returns with out_valid.
// Reset clears the controller and the output valid flag. A finished result waits in the
// output register while the next item runs; only a second result that finds it full waits.

module epoch_seconds_to_calendar_top (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [esc_pkg::EPOCH_W-1:0]   epoch_seconds,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic      [esc_pkg::SEC_W-1:0]     second_of_minute,
    output logic      [esc_pkg::MIN_W-1:0]     minute_of_hour,
    output logic      [esc_pkg::HOUR_W-1:0]    hour_of_day,
    output logic      [esc_pkg::DAY_W-1:0]     day_of_month,
    output logic      [esc_pkg::MONTH_W-1:0]   month_of_year,
    output logic      [esc_pkg::YEAR_W-1:0]    calendar_year
);
    import esc_pkg::*;

    esc_cmd_t    cmd;
    esc_status_t status;

    // Sequencer.
    esc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .status    (status)
    );

    // Time-of-day split, calendar walk and output register.
    esc_dp u_dp (
        .clk              (clk),
        .cmd              (cmd),
        .status           (status),
        .epoch_seconds    (epoch_seconds),
        .second_of_minute (second_of_minute),
        .minute_of_hour   (minute_of_hour),
        .hour_of_day      (hour_of_day),
        .day_of_month     (day_of_month),
        .month_of_year    (month_of_year),
        .calendar_year    (calendar_year)
    );

    // A transfer in starts the conversion, so the input side is busy next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while a conversion was running");

    // Time-of-day fields of a presented result lie within their ranges.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (second_of_minute <= 6'd59) && (minute_of_hour <= 6'd59) &&
                      (hour_of_day <= 5'd23))
        else $error("time of day out of range");

    // Calendar fields of a presented result lie within their ranges.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (month_of_year <= LAST_MONTH) && (day_of_month <= 5'd30) &&
                      (calendar_year >= FIRST_YEAR) && (calendar_year <= 12'd2136))
        else $error("calendar date out of range");

endmodule

`default_nettype wire

### hdl/esc_dp.sv
`default_nettype none

module esc_dp (
    input  wire logic                          clk,
    input  wire esc_pkg::esc_cmd_t             cmd,
    output esc_pkg::esc_status_t               status,
    input  wire logic [esc_pkg::EPOCH_W-1:0]   epoch_seconds,
    output logic      [esc_pkg::SEC_W-1:0]     second_of_minute,
    output logic      [esc_pkg::MIN_W-1:0]     minute_of_hour,
    output logic      [esc_pkg::HOUR_W-1:0]    hour_of_day,
    output logic      [esc_pkg::DAY_W-1:0]     day_of_month,
    output logic      [esc_pkg::MONTH_W-1:0]   month_of_year,
    output logic      [esc_pkg::YEAR_W-1:0]    calendar_year
);
    import esc_pkg::*;

    // Seconds count and its split into time of day.
    logic [EPOCH_W-1:0] secs_reg;
    logic [REM_W-1:0]   tod_reg;
    logic [HREM_W-1:0]  rest_reg;

    // Time of day and calendar walk.
    logic [SEC_W-1:0]   sec_reg;
    logic [MIN_W-1:0]   min_reg;
    logic [HOUR_W-1:0]  hour_reg;
    logic [DAYS_W-1:0]  days_reg;
    logic [YEAR_W-1:0]  year_reg;
    logic [1:0]         y4_reg;
    logic [6:0]         y100_reg;
    logic [1:0]         y400_reg;
    logic [MONTH_W-1:0] month_reg;

    // Output register.
    logic [SEC_W-1:0]   out_sec_reg;
    logic [MIN_W-1:0]   out_min_reg;
    logic [HOUR_W-1:0]  out_hour_reg;
    logic [DAY_W-1:0]   out_day_reg;
    logic [MONTH_W-1:0] out_month_reg;
    logic [YEAR_W-1:0]  out_year_reg;

    logic [DAY_PROD_W-1:0]      day_prod;
    logic [DAYS_W+REM_W-1:0]    day_back;
    logic [HOUR_PROD_W-1:0]     hour_prod;
    logic [HOUR_W+HREM_W-1:0]   hour_back;
    logic [MIN_PROD_W-1:0]      min_prod;
    logic [MIN_W+SEC_W-1:0]     min_back;
    logic                       leap;
    logic [YDAYS_W-1:0]         year_len;
    logic [DAY_W:0]             mon_len;

    // Quotients by reciprocal multiplication and products for the remainders.
    always_comb
    begin
        day_prod  = {{DAY_RCP_W{1'b0}}, secs_reg[EPOCH_W-1:DAY_PRE]} *
                    {{(EPOCH_W-DAY_PRE){1'b0}}, DAY_RCP};
        day_back  = {{REM_W{1'b0}}, days_reg} * {{DAYS_W{1'b0}}, SECS_PER_DAY};
        hour_prod = {{HOUR_RCP_W{1'b0}}, tod_reg[REM_W-1:HOUR_PRE]} *
                    {{(REM_W-HOUR_PRE){1'b0}}, HOUR_RCP};
        hour_back = {{HREM_W{1'b0}}, hour_reg} * {{HOUR_W{1'b0}}, SECS_PER_HOUR};
        min_prod  = {{MIN_RCP_W{1'b0}}, rest_reg[HREM_W-1:MIN_PRE]} *
                    {{(HREM_W-MIN_PRE){1'b0}}, MIN_RCP};
        min_back  = {{SEC_W{1'b0}}, min_reg} * {{MIN_W{1'b0}}, SECS_PER_MIN};
    end

    // Gregorian leap rule from the year counters modulo 4, 100 and 400.
    always_comb
    begin
        leap     = (y4_reg == 2'd0) && ((y100_reg != 7'd0) || (y400_reg == 2'd0));
        year_len = leap ? DAYS_LEAP : DAYS_COMMON;
        mon_len  = month_len(leap, month_reg);
    end

    // Status towards the controller.
    always_comb
    begin
        status.year_more  = (days_reg >= {{(DAYS_W-YDAYS_W){1'b0}}, year_len});
        status.month_more = (month_reg < LAST_MONTH) &&
                            (days_reg >= {{(DAYS_W-DAY_W-1){1'b0}}, mon_len});
    end

    // Time of day, one quotient or remainder per cycle. Each remainder is below
    // its divisor, so only the low bits of the subtraction are kept.
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            secs_reg <= epoch_seconds;
        end
        if (cmd.day_rem)
        begin
            tod_reg <= secs_reg[REM_W-1:0] - day_back[REM_W-1:0];
        end
        if (cmd.hour_quo)
        begin
            hour_reg <= hour_prod[HOUR_SH+HOUR_W-1:HOUR_SH];
        end
        if (cmd.hour_rem)
        begin
            rest_reg <= tod_reg[HREM_W-1:0] - hour_back[HREM_W-1:0];
        end
        if (cmd.min_quo)
        begin
            min_reg <= min_prod[MIN_SH+MIN_W-1:MIN_SH];
        end
        if (cmd.min_rem)
        begin
            sec_reg <= rest_reg[SEC_W-1:0] - min_back[SEC_W-1:0];
        end
    end

    // Year and month walk over the whole-day count.
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            year_reg  <= FIRST_YEAR;
            y4_reg    <= '0;
            y100_reg  <= '0;
            y400_reg  <= '0;
            month_reg <= '0;
        end
        else if (cmd.day_quo)
        begin
            days_reg <= day_prod[DAY_SH+DAYS_W-1:DAY_SH];
        end
        else if (cmd.year_step)
        begin
            days_reg <= days_reg - {{(DAYS_W-YDAYS_W){1'b0}}, year_len};
            year_reg <= year_reg + 12'd1;
            y4_reg   <= y4_reg + 2'd1;
            if (y100_reg == LAST_YEAR_OF_CENTURY)
            begin
                y100_reg <= '0;
                y400_reg <= y400_reg + 2'd1;
            end
            else
            begin
                y100_reg <= y100_reg + 7'd1;
            end
        end
        else if (cmd.month_step)
        begin
            days_reg  <= days_reg - {{(DAYS_W-DAY_W-1){1'b0}}, mon_len};
            month_reg <= month_reg + 4'd1;
        end
    end

    // Output register, loaded once the walk has finished.
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_sec_reg   <= sec_reg;
            out_min_reg   <= min_reg;
            out_hour_reg  <= hour_reg;
            out_day_reg   <= days_reg[DAY_W-1:0];
            out_month_reg <= month_reg;
            out_year_reg  <= year_reg;
        end
    end

    assign second_of_minute = out_sec_reg;
    assign minute_of_hour   = out_min_reg;
    assign hour_of_day      = out_hour_reg;
    assign day_of_month     = out_day_reg;
    assign month_of_year    = out_month_reg;
    assign calendar_year    = out_year_reg;

endmodule

`default_nettype wire

### hdl/esc_ctrl.sv
`default_nettype none

module esc_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output esc_pkg::esc_cmd_t         cmd,
    input  wire esc_pkg::esc_status_t status
);
    import esc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DAY_QUO,
        S_DAY_REM,
        S_HOUR_QUO,
        S_HOUR_REM,
        S_MIN_QUO,
        S_MIN_REM,
        S_YEAR,
        S_MONTH,
        S_FINISH
    } state_t;

    state_t     state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    // Next state and datapath commands.
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.start  = 1'b1;
                    state_next = S_DAY_QUO;
                end
            end
            S_DAY_QUO:
            begin
                cmd.day_quo = 1'b1;
                state_next  = S_DAY_REM;
            end
            S_DAY_REM:
            begin
                cmd.day_rem = 1'b1;
                state_next  = S_HOUR_QUO;
            end
            S_HOUR_QUO:
            begin
                cmd.hour_quo = 1'b1;
                state_next   = S_HOUR_REM;
            end
            S_HOUR_REM:
            begin
                cmd.hour_rem = 1'b1;
                state_next   = S_MIN_QUO;
            end
            S_MIN_QUO:
            begin
                cmd.min_quo = 1'b1;
                state_next  = S_MIN_REM;
            end
            S_MIN_REM:
            begin
                cmd.min_rem = 1'b1;
                state_next  = S_YEAR;
            end
            S_YEAR:
            begin
                if (status.year_more)
                begin
                    cmd.year_step = 1'b1;
                end
                else
                begin
                    state_next = S_MONTH;
                end
            end
            S_MONTH:
            begin
                if (status.month_more)
                begin
                    cmd.month_step = 1'b1;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                // Wait until the output register is free or being emptied.
                if (out_free)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire
